/* rtl/hcbm_pkg.sv */
// Shared types, constants and the mod-26 reduction for the Hill cipher block multiplier.
package hcbm_pkg;

  localparam int KEY_DIM   = 4;
  localparam int ROW_W     = 2;
  localparam int LETTER_W  = 5;
  localparam int KEY_ROW_W = KEY_DIM * LETTER_W;
  localparam int PROD_W    = 2 * LETTER_W;
  localparam int BSIZE_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [PROD_W-1:0] ALPHABET = 10'd26;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LETTER = 3'd5;

  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST = 3'd2;
  localparam logic [LETTER_W-1:0] PAD_LETTER_RST = 5'd23;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                message_end;
  } hcbm_in_t;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                block_last;
    logic                message_last;
  } hcbm_out_t;

  // One output row travelling down the cell chain
  typedef struct packed {
    logic                valid;
    logic [ROW_W-1:0]    row;
    logic                block_last;
    logic                message_last;
    logic [LETTER_W-1:0] partial;
  } hcbm_tok_t;

  // Letter write into one cell
  typedef struct packed {
    logic                wr;
    logic [LETTER_W-1:0] letter;
  } hcbm_load_t;

  typedef logic [KEY_DIM-1:0][KEY_ROW_W-1:0] hcbm_key_t;
  typedef logic [KEY_DIM-1:0][LETTER_W-1:0]  hcbm_kcol_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ISSUE,
    ST_DRAIN
  } hcbm_state_e;

  // s mod 26 for s < 1024: reciprocal estimate (never high, at most one low), then one fix-up
  function automatic logic [LETTER_W-1:0] mod26(input logic [PROD_W-1:0] s);
    logic [18:0] t;
    logic [5:0]  q;
    logic [PROD_W-1:0] r;
    t = 19'(s) * 19'd315;
    q = t[18:13];
    r = s - PROD_W'(q) * ALPHABET;
    if (r >= ALPHABET) begin
      r = r - ALPHABET;
    end
    return r[LETTER_W-1:0];
  endfunction

endpackage

/* rtl/hcbm_cell.sv */
// One cell of the chain: holds one block letter and adds its key product to a passing row.
module hcbm_cell import hcbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       active_i,
  input  hcbm_load_t load_i,
  input  hcbm_kcol_t key_col_i,
  input  hcbm_tok_t  tok_i,
  output hcbm_tok_t  tok_o
);

  logic [LETTER_W-1:0] letter_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  hcbm_tok_t           s1_q, s2_d, s2_q;

  always_ff @(posedge clk_i) begin
    if (load_i.wr) begin
      letter_q <= load_i.letter;
    end
  end

  // stage 1: key entry times letter; idle cells add nothing
  assign prod_d = active_i ? PROD_W'(key_col_i[tok_i.row]) * PROD_W'(letter_q) : '0;

  always_comb begin
    s2_d         = s1_q;
    s2_d.partial = mod26(PROD_W'(s1_q.partial) + prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= tok_i;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign tok_o = s2_q;

endmodule

/* rtl/hill_cipher_block_multiply.sv */
// Top level of the Hill cipher block multiplier: config, letter intake, row sequencer, cell chain.
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i): one letter index 0..25 per word,
//   with message_end on the final letter of a message.
// - Output channel (out_valid_o / out_stall_i / out_data_o): one cipher letter per letter
//   of each closed block; block_last on the last row, message_last when the message end
//   closed that block. A short final block is completed with the pad letter.
// - Config port: cfg_we_i writes cfg_data_i into register cfg_index_i (block size, four key
//   rows, pad letter). Write only while no block is in flight.
// - Letters are taken one per cycle while a block fills. Once a block closes, in_stall_o
//   stays high until its last cipher letter has been taken.
// - Rows enter a chain of MAX_BLOCK cells, each two register stages deep, and every row
//   passes through all of them whatever the block size; cipher letters then leave the
//   chain one per cycle while out_stall_i is low.
// - out_stall_i freezes the whole chain while a word waits; that word holds on out_data_o.
// - Reset: block size 2, key rows 0, pad letter 23, empty block, chain empty.
module hill_cipher_block_multiply import hcbm_pkg::*; #(
  parameter int MAX_BLOCK = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_ROW_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcbm_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hcbm_out_t            out_data_o
);

  localparam int FW    = $clog2(MAX_BLOCK + 1);
  localparam int LIMIT = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;

  // config registers
  logic [BSIZE_W-1:0]  block_size_q;
  hcbm_key_t           key_q;
  logic [LETTER_W-1:0] pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
      key_q        <= '0;
      pad_q        <= PAD_LETTER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_SIZE: block_size_q <= cfg_data_i[BSIZE_W-1:0];
        REG_KEY_ROW0:   key_q[0]     <= cfg_data_i;
        REG_KEY_ROW1:   key_q[1]     <= cfg_data_i;
        REG_KEY_ROW2:   key_q[2]     <= cfg_data_i;
        REG_KEY_ROW3:   key_q[3]     <= cfg_data_i;
        REG_PAD_LETTER: pad_q        <= cfg_data_i[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  // block size in use: 0 acts as 1, clamp to what the key and chain support
  logic [FW-1:0] n_w;
  always_comb begin
    priority if (block_size_q == '0) begin
      n_w = FW'(1);
    end else if (block_size_q > BSIZE_W'(LIMIT)) begin
      n_w = FW'(LIMIT);
    end else begin
      n_w = FW'(block_size_q);
    end
  end

  hcbm_state_e      state_q, state_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    nrows_q, nrows_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             end_q, end_d;

  logic          in_acc, out_acc, adv, close, last_row;
  logic [FW-1:0] wpos, pos;
  hcbm_tok_t     tok [MAX_BLOCK+1];

  assign in_stall_o = (state_q != ST_COLLECT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign adv        = !tok[MAX_BLOCK].valid || !out_stall_i;

  // a lowered block size overwrites the last slot and closes the block
  assign wpos  = (fill_q >= n_w) ? n_w - FW'(1) : fill_q;
  assign pos   = wpos + FW'(1);
  assign close = (pos == n_w) || in_data_i.message_end;

  assign last_row = ({1'b0, row_q} + 3'd1) == 3'(nrows_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
      nrows_q <= '0;
      row_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      nrows_q <= nrows_d;
      row_q   <= row_d;
      end_q   <= end_d;
    end
  end

  // sequencer: collect letters, feed one row per unstalled cycle, wait for the last word
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    nrows_d = nrows_q;
    row_d   = row_q;
    end_d   = end_q;
    tok[0]  = '0;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (close) begin
            fill_d  = '0;
            nrows_d = n_w;
            end_d   = in_data_i.message_end;
            row_d   = '0;
            state_d = ST_ISSUE;
          end else begin
            fill_d = pos;
          end
        end
      end
      ST_ISSUE: begin
        tok[0].valid        = 1'b1;
        tok[0].row          = row_q;
        tok[0].block_last   = last_row;
        tok[0].message_last = last_row && end_q;
        if (adv) begin
          row_d = row_q + ROW_W'(1);
          if (last_row) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_data_o.block_last) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // cell chain
  for (genvar k = 0; k < MAX_BLOCK; k++) begin : g_cell
    hcbm_load_t ld;
    hcbm_kcol_t kcol;
    logic       active;

    always_comb begin
      ld.wr     = in_acc && ((FW'(k) == wpos) ||
                             (close && (FW'(k) > wpos) && (FW'(k) < n_w)));
      ld.letter = (FW'(k) == wpos) ? in_data_i.letter : pad_q;
    end

    assign active = FW'(k) < nrows_q;

    for (genvar r = 0; r < KEY_DIM; r++) begin : g_kcol
      if (k < KEY_DIM) begin : g_key
        assign kcol[r] = key_q[r][LETTER_W*k +: LETTER_W];
      end else begin : g_nokey
        assign kcol[r] = '0;
      end
    end

    hcbm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .active_i  (active),
      .load_i    (ld),
      .key_col_i (kcol),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1])
    );
  end

  assign out_valid_o              = tok[MAX_BLOCK].valid;
  assign out_data_o.cipher_letter = tok[MAX_BLOCK].partial;
  assign out_data_o.block_last    = tok[MAX_BLOCK].block_last;
  assign out_data_o.message_last  = tok[MAX_BLOCK].message_last;

  // chain is empty whenever letters are being collected
  a_collect_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COLLECT |-> !out_valid_o)
    else $error("word on output while collecting letters");

  a_msg_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.message_last |-> out_data_o.block_last)
    else $error("message_last without block_last");

  a_close_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && close |=> state_q == ST_ISSUE && fill_q == '0)
    else $error("closed block did not start row issue");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |-> FW'(row_q) < nrows_q)
    else $error("row counter past block size");

  a_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.block_last |=> state_q == ST_COLLECT)
    else $error("intake not reopened after last row");

endmodule

/* tb/hcbm_cipher_checker.sv */
// Channel monitor, cipher word predictor and scoreboard for the Hill cipher block multiplier.
`timescale 1ns / 100ps
module hcbm_cipher_checker import hcbm_pkg::*; #(
  parameter int MAX_BLOCK = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_ROW_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  hcbm_in_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  hcbm_out_t            out_data_i,
  output int                   mismatch_count_o,
  output int                   words_due_o,
  output int                   words_checked_o
);

  localparam int SIZE_LIMIT = (MAX_BLOCK < KEY_DIM) ? MAX_BLOCK : KEY_DIM;

  logic [BSIZE_W-1:0]   size_reg;
  logic [KEY_ROW_W-1:0] key_row [KEY_DIM];
  logic [LETTER_W-1:0]  pad_reg;
  logic [LETTER_W-1:0]  open_block [KEY_DIM];
  int unsigned          fill;
  hcbm_out_t            cipher_due [$];

  function automatic int unsigned size_in_use(logic [BSIZE_W-1:0] raw);
    int unsigned n;
    n = raw;
    if (n == 0) n = 1;
    if (n > SIZE_LIMIT) n = SIZE_LIMIT;
    return n;
  endfunction

  // Adds one letter to the open block; a closed block yields one word per block letter.
  task automatic encipher_letter(hcbm_in_t word);
    int unsigned n, pos, sum, j, k;
    hcbm_out_t   c;
    n = size_in_use(size_reg);
    pos = (fill >= n) ? n - 1 : fill;
    open_block[pos] = word.letter;
    pos++;
    fill = pos;
    if (pos >= n || word.message_end) begin
      for (k = pos; k < n; k++) open_block[k] = pad_reg;
      for (j = 0; j < n; j++) begin
        sum = 0;
        for (k = 0; k < n; k++) begin
          sum = sum + key_row[j][LETTER_W*k +: LETTER_W] * open_block[k];
        end
        c.cipher_letter = LETTER_W'(sum % int'(ALPHABET));
        c.block_last    = (j + 1 == n);
        c.message_last  = (j + 1 == n) && word.message_end;
        cipher_due.push_back(c);
      end
      fill = 0;
    end
  endtask

  task automatic check_word(hcbm_out_t got);
    hcbm_out_t want;
    if (cipher_due.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: unexpected word letter %0d block_last %0b message_last %0b",
                 $realtime, got.cipher_letter, got.block_last, got.message_last);
    end else begin
      want = cipher_due.pop_front();
      words_checked_o++;
      if (got.cipher_letter !== want.cipher_letter || got.block_last !== want.block_last ||
          got.message_last !== want.message_last) begin
        mismatch_count_o++;
        if (mismatch_count_o <= 10)
          $display("%0t: word %0d expected letter %0d bl %0b ml %0b, got letter %0d bl %0b ml %0b",
                   $realtime, words_checked_o, want.cipher_letter, want.block_last,
                   want.message_last, got.cipher_letter, got.block_last, got.message_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg = BLOCK_SIZE_RST;
      pad_reg  = PAD_LETTER_RST;
      for (int i = 0; i < KEY_DIM; i++) begin
        key_row[i]    = '0;
        open_block[i] = '0;
      end
      fill = 0;
      cipher_due.delete();
      mismatch_count_o = 0;
      words_checked_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) encipher_letter(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_BLOCK_SIZE: size_reg   = cfg_data_i[BSIZE_W-1:0];
          REG_KEY_ROW0:   key_row[0] = cfg_data_i;
          REG_KEY_ROW1:   key_row[1] = cfg_data_i;
          REG_KEY_ROW2:   key_row[2] = cfg_data_i;
          REG_KEY_ROW3:   key_row[3] = cfg_data_i;
          REG_PAD_LETTER: pad_reg    = cfg_data_i[LETTER_W-1:0];
          default: ;
        endcase
      end
    end
    words_due_o = cipher_due.size();
  end

endmodule

/* tb/hill_cipher_block_multiply_tb.sv */
// Testbench top for the Hill cipher block multiplier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module hill_cipher_block_multiply_tb;
  import hcbm_pkg::*;

  localparam int MAX_BLOCK      = 4;
  localparam int RANDOM_LETTERS = 310;
  // Chain depth plus slack, waited out after every predicted word is back
  localparam int SETTLE         = 2 * MAX_BLOCK + 8;
  // Cycle limit for the watchdog
  localparam int CYCLE_LIMIT    = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_ROW_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  hcbm_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  hcbm_out_t            out_data;

  int mismatches;
  int words_due;
  int words_checked;
  int letters_sent    = 0;
  int settings_loaded = 0;
  int cycles          = 0;
  bit steady          = 1'b0;   // no idling on either side while set

  hill_cipher_block_multiply #(.MAX_BLOCK(MAX_BLOCK)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  hcbm_cipher_checker #(.MAX_BLOCK(MAX_BLOCK)) cipher_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .words_due_o      (words_due),
    .words_checked_o  (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d cipher words outstanding", cycles, words_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Key row with entry k in bits 5k..5k+4
  function automatic logic [KEY_ROW_W-1:0] pack_key_row(int e0, int e1, int e2, int e3);
    return {LETTER_W'(e3), LETTER_W'(e2), LETTER_W'(e1), LETTER_W'(e0)};
  endfunction

  // Mostly proper entries 0..25; now and then a raw 20-bit pattern with entries up to 31
  function automatic logic [KEY_ROW_W-1:0] random_key_row();
    if ($urandom_range(0, 4) == 0) return KEY_ROW_W'($urandom);
    return pack_key_row($urandom_range(0, 25), $urandom_range(0, 25),
                        $urandom_range(0, 25), $urandom_range(0, 25));
  endfunction

  // One register write; leaves the write enable low at the next falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_ROW_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setting(int size, logic [KEY_ROW_W-1:0] r0, logic [KEY_ROW_W-1:0] r1,
                              logic [KEY_ROW_W-1:0] r2, logic [KEY_ROW_W-1:0] r3,
                              logic [LETTER_W-1:0] pad);
    write_reg(REG_BLOCK_SIZE, KEY_ROW_W'(size));
    write_reg(REG_KEY_ROW0, r0);
    write_reg(REG_KEY_ROW1, r1);
    write_reg(REG_KEY_ROW2, r2);
    write_reg(REG_KEY_ROW3, r3);
    write_reg(REG_PAD_LETTER, KEY_ROW_W'(pad));
    settings_loaded++;
  endtask

  // Offers one word after a random gap and returns at the edge that takes it.
  // Valid stays high from one word to the next when the gap is zero.
  task automatic send_letter(logic [LETTER_W-1:0] letter, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid            = 1'b0;
      in_data.letter      = LETTER_W'($urandom_range(0, 31));   // junk while idle
      in_data.message_end = 1'b1;
    end
    @(negedge clk);
    in_valid            = 1'b1;
    in_data.letter      = letter;
    in_data.message_end = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    letters_sent++;
  endtask

  // Sender holds off until every predicted word is back and the chain has emptied
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (words_due == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: per word, a stall of random length, then stall low until a word is taken
  initial begin : sink
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int                   target, phase_len, count, msg_len, i, size, pick;
    bit                   open_msg;
    logic [KEY_ROW_W-1:0] rows [KEY_DIM];
    logic [LETTER_W-1:0]  pad, letter;
    logic                 last;

    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_BLOCK_SIZE;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- Directed part ---

    // Reset values: two-letter blocks, zero key, final short block gets the reset pad
    send_letter(5'd7, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd19, 1'b1);
    drain();

    // Textbook 2x2 key on a four-letter message
    load_setting(2, pack_key_row(3, 3, 0, 0), pack_key_row(2, 5, 0, 0), '0, '0, 5'd23);
    send_letter(5'd7, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd11, 1'b0);
    send_letter(5'd15, 1'b1);
    drain();

    // Its inverse mod 26 loaded: the first cipher pair should decrypt back
    load_setting(2, pack_key_row(15, 17, 0, 0), pack_key_row(20, 9, 0, 0), '0, '0, 5'd23);
    send_letter(5'd7, 1'b0);
    send_letter(5'd8, 1'b1);
    drain();

    // Every key entry, letter and pad at the 5-bit ceiling; then a block padded by three
    load_setting(4, '1, '1, '1, '1, 5'd31);
    repeat (4) send_letter(5'd31, 1'b0);
    send_letter(5'd0, 1'b1);
    drain();

    // Size zero runs as one-letter blocks; message end falls on a full block
    load_setting(0, random_key_row(), random_key_row(), random_key_row(), random_key_row(),
                 5'd0);
    send_letter(5'd25, 1'b1);
    drain();

    // Size seven clamps to four; message end on a full block, no padding
    load_setting(7, random_key_row(), random_key_row(), random_key_row(), random_key_row(),
                 5'd25);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd30, 1'b1);
    drain();

    // Block size lowered with the block part filled: last slot overwritten, block closes
    write_reg(REG_BLOCK_SIZE, KEY_ROW_W'(4));
    send_letter(5'd5, 1'b0);
    send_letter(5'd6, 1'b0);
    send_letter(5'd26, 1'b0);
    drain();
    write_reg(REG_BLOCK_SIZE, KEY_ROW_W'(2));
    send_letter(5'd9, 1'b0);
    drain();

    // Block size raised with the block part filled: stays open, padded at message end
    send_letter(5'd12, 1'b0);
    drain();
    write_reg(REG_BLOCK_SIZE, KEY_ROW_W'(3));
    send_letter(5'd13, 1'b1);
    drain();

    // --- Random part: one register setting per phase, messages of random content ---
    target = letters_sent + RANDOM_LETTERS;
    while (letters_sent < target) begin
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      size   = (pick < 8) ? 1 + pick % 4 : $urandom_range(0, 7);
      for (i = 0; i < KEY_DIM; i++) rows[i] = random_key_row();
      pad = ($urandom_range(0, 4) == 0) ? LETTER_W'($urandom_range(26, 31))
                                        : LETTER_W'($urandom_range(0, 25));
      load_setting(size, rows[0], rows[1], rows[2], rows[3], pad);

      phase_len = $urandom_range(20, 40);
      count     = 0;
      while (count < phase_len) begin
        msg_len  = $urandom_range(1, 12);
        // Some messages lose their end marker and run on into the next one
        open_msg = ($urandom_range(0, 5) == 0);
        for (i = 0; i < msg_len; i++) begin
          letter = ($urandom_range(0, 7) == 0) ? LETTER_W'($urandom_range(26, 31))
                                               : LETTER_W'($urandom_range(0, 25));
          last   = (i == msg_len - 1) ? !open_msg : ($urandom_range(0, 15) == 0);
          send_letter(letter, last);
        end
        count += msg_len;
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    steady = 1'b0;
    drain();

    $display("Sent %0d letters under %0d register settings (sizes 0..7, extreme keys and pads);",
             letters_sent, settings_loaded);
    $display("compared %0d cipher words with random gaps and output stalls.", words_checked);
    if (mismatches == 0 && words_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hcbm_pkg.sv
rtl/hcbm_cell.sv
rtl/hill_cipher_block_multiply.sv
tb/hcbm_cipher_checker.sv
tb/hill_cipher_block_multiply_tb.sv
